// ===== design/gdef_pkg.sv =====
// shared types, widths and codes of the grid deviation event filter
`default_nettype none

package gdef_pkg;

    // field widths
    localparam int TAG_W  = 16;
    localparam int FREQ_W = 18;
    localparam int VRMS_W = 16;
    localparam int DUR_W  = 16;
    localparam int GOOD_W = 17;
    localparam int KIND_W = 2;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 18;

    // default merge limit while accumulating
    localparam int MAX_EXTEND_DEF = 15;

    // saturation values
    localparam logic [GOOD_W-1:0] GOOD_MAX = {GOOD_W{1'b1}};
    localparam logic [DUR_W-1:0]  DUR_MAX  = {DUR_W{1'b1}};

    // register reset values
    localparam logic [FREQ_W-1:0] FREQ_EXP_RST = FREQ_W'(60000);
    localparam logic [VRMS_W-1:0] VRMS_EXP_RST = VRMS_W'(12000);
    localparam logic [FREQ_W-1:0] FREQ_THR_RST = FREQ_W'(100);
    localparam logic [VRMS_W-1:0] VRMS_THR_RST = VRMS_W'(500);
    localparam logic [15:0]       MEAS_PER_RST = 16'd0;

    // frame classification codes
    typedef enum logic [KIND_W-1:0] {
        KIND_FREQ = 2'd0,
        KIND_VOLT = 2'd1,
        KIND_MEAS = 2'd2
    } kind_t;

    // configuration register indexes
    typedef enum logic [ADDR_W-1:0] {
        REG_FREQ_EXP = 3'd0,
        REG_VRMS_EXP = 3'd1,
        REG_FREQ_THR = 3'd2,
        REG_VRMS_THR = 3'd3,
        REG_MEAS_PER = 3'd4
    } reg_addr_t;

    // classifier settings
    typedef struct packed {
        logic [FREQ_W-1:0] freq_expected;
        logic [VRMS_W-1:0] vrms_expected;
        logic [FREQ_W-1:0] freq_threshold;
        logic [VRMS_W-1:0] vrms_threshold;
    } class_cfg_t;

    // classifier verdict
    typedef struct packed {
        logic  is_event;
        kind_t kind;
    } class_t;

    // one captured frame
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [FREQ_W-1:0] freq;
        logic [VRMS_W-1:0] vrms;
        logic [DUR_W-1:0]  duration;
    } frame_t;

endpackage

`default_nettype wire

// ===== design/gdef_if.sv =====
// channel interfaces: frame input, result output, configuration write
`default_nettype none

interface gdef_frame_if;
    logic                        valid;
    logic                        ready;
    logic [gdef_pkg::TAG_W-1:0]  frame_tag;
    logic [gdef_pkg::FREQ_W-1:0] freq_meas;
    logic [gdef_pkg::VRMS_W-1:0] vrms_meas;
    logic [gdef_pkg::DUR_W-1:0]  frame_duration;

    modport source (output valid, frame_tag, freq_meas, vrms_meas, frame_duration,
                    input ready);
    modport sink   (input valid, frame_tag, freq_meas, vrms_meas, frame_duration,
                    output ready);
endinterface

interface gdef_result_if;
    logic                        valid;
    logic                        ready;
    logic                        emit;
    logic [gdef_pkg::KIND_W-1:0] event_kind;
    logic [gdef_pkg::TAG_W-1:0]  out_tag;
    logic [gdef_pkg::FREQ_W-1:0] out_freq;
    logic [gdef_pkg::VRMS_W-1:0] out_vrms;
    logic [gdef_pkg::DUR_W-1:0]  out_duration;
    logic                        led_on;

    modport source (output valid, emit, event_kind, out_tag, out_freq, out_vrms,
                    out_duration, led_on, input ready);
    modport sink   (input valid, emit, event_kind, out_tag, out_freq, out_vrms,
                    out_duration, led_on, output ready);
endinterface

interface gdef_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [gdef_pkg::ADDR_W-1:0] addr;
    logic [gdef_pkg::DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ===== design/gdef_classify.sv =====
// frequency and voltage deviation compare for one frame
`default_nettype none

module gdef_classify (
    input  gdef_pkg::class_cfg_t          cfg,
    input  logic [gdef_pkg::FREQ_W-1:0]   freq,
    input  logic [gdef_pkg::VRMS_W-1:0]   vrms,
    output gdef_pkg::class_t              verdict
);
    import gdef_pkg::*;

    logic [FREQ_W-1:0] freq_dev;
    logic [VRMS_W-1:0] vrms_dev;
    logic              freq_hit;
    logic              vrms_hit;

    // absolute deviations from nominal
    assign freq_dev = (cfg.freq_expected >= freq) ? (cfg.freq_expected - freq)
                                                  : (freq - cfg.freq_expected);
    assign vrms_dev = (cfg.vrms_expected >= vrms) ? (cfg.vrms_expected - vrms)
                                                  : (vrms - cfg.vrms_expected);

    assign freq_hit = (freq_dev >= cfg.freq_threshold);
    assign vrms_hit = (vrms_dev >= cfg.vrms_threshold);

    // frequency wins over voltage; measurement kind is decided by the caller
    always_comb
    begin
        verdict.is_event = freq_hit | vrms_hit;
        verdict.kind     = freq_hit ? KIND_FREQ : (vrms_hit ? KIND_VOLT : KIND_MEAS);
    end

endmodule

`default_nettype wire

// ===== design/grid_deviation_event_filter.sv =====
// top level of the grid deviation event filter
//
//  channel  | dir | beat contents
//  ---------+-----+--------------------------------------------------------
//  frame    | in  | frame_tag, freq_meas, vrms_meas, frame_duration
//  result   | out | emit, event_kind, out_tag, out_freq, out_vrms, out_duration,
//           |     | led_on
//  cfg      | in  | addr (register index), data
//
// every frame beat gives exactly one result beat, through the input register and the result register
// one frame per cycle sustained while result.ready is high: classification, counters and the held frame
// update in the single step from the input register to the result register
// a stalled result holds the result register and then the input register;
// frame.ready stays high while either of them can move
// reset clears the valid flags and counters and loads the configuration reset values; cfg.ready is always high
`default_nettype none

module grid_deviation_event_filter #(
    parameter int MAX_EXTEND = gdef_pkg::MAX_EXTEND_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    gdef_frame_if.sink  frame,
    gdef_result_if.source result,
    gdef_cfg_if.sink    cfg
);
    import gdef_pkg::*;

    localparam int EXT_W = $clog2(MAX_EXTEND + 1);

    // configuration registers
    logic [FREQ_W-1:0] freq_exp_reg;
    logic [VRMS_W-1:0] vrms_exp_reg;
    logic [FREQ_W-1:0] freq_thr_reg;
    logic [VRMS_W-1:0] vrms_thr_reg;
    logic [15:0]       meas_per_reg;

    // input stage
    logic   in_valid_reg;
    frame_t in_frame_reg;

    // filter state
    logic              accum_reg,  accum_next;
    logic [GOOD_W-1:0] good_reg,   good_next;
    logic [EXT_W-1:0]  ext_reg,    ext_next;
    frame_t            held_reg,   held_next;
    kind_t             hkind_reg,  hkind_next;

    // result stage
    logic              out_valid_reg;
    logic              emit_reg,   emit_next;
    kind_t             kind_reg,   kind_next;
    frame_t            out_reg,    out_next;
    logic              led_reg,    led_next;

    logic       advance;
    class_cfg_t class_cfg;
    class_t     verdict;
    logic [GOOD_W-1:0] good_inc;
    logic       is_meas;

    assign cfg.ready   = 1'b1;
    assign advance     = in_valid_reg & (~out_valid_reg | result.ready);
    assign frame.ready = ~in_valid_reg | advance;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_exp_reg <= FREQ_EXP_RST;
            vrms_exp_reg <= VRMS_EXP_RST;
            freq_thr_reg <= FREQ_THR_RST;
            vrms_thr_reg <= VRMS_THR_RST;
            meas_per_reg <= MEAS_PER_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                REG_FREQ_EXP: freq_exp_reg <= cfg.data[FREQ_W-1:0];
                REG_VRMS_EXP: vrms_exp_reg <= cfg.data[VRMS_W-1:0];
                REG_FREQ_THR: freq_thr_reg <= cfg.data[FREQ_W-1:0];
                REG_VRMS_THR: vrms_thr_reg <= cfg.data[VRMS_W-1:0];
                REG_MEAS_PER: meas_per_reg <= cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // deviation compare
    assign class_cfg.freq_expected  = freq_exp_reg;
    assign class_cfg.vrms_expected  = vrms_exp_reg;
    assign class_cfg.freq_threshold = freq_thr_reg;
    assign class_cfg.vrms_threshold = vrms_thr_reg;

    gdef_classify u_classify (
        .cfg     (class_cfg),
        .freq    (in_frame_reg.freq),
        .vrms    (in_frame_reg.vrms),
        .verdict (verdict)
    );

    // good-frame count and periodic measurement decision
    assign good_inc = (good_reg != GOOD_MAX) ? (good_reg + GOOD_W'(1)) : good_reg;
    assign is_meas  = ~verdict.is_event & (meas_per_reg != 16'd0) &
                      (good_inc > {1'b0, meas_per_reg});

    // hold, merge and emit decision
    always_comb
    begin
        accum_next = accum_reg;
        ext_next   = ext_reg;
        held_next  = held_reg;
        hkind_next = hkind_reg;
        emit_next  = 1'b0;
        kind_next  = KIND_FREQ;
        out_next   = '0;
        led_next   = verdict.is_event | is_meas;

        if (verdict.is_event || is_meas)
            good_next = '0;
        else
            good_next = good_inc;

        if (!accum_reg)
        begin
            if (verdict.is_event)
            begin
                held_next  = in_frame_reg;
                hkind_next = verdict.kind;
                accum_next = 1'b1;
            end
            else if (is_meas)
            begin
                emit_next = 1'b1;
                kind_next = KIND_MEAS;
                out_next  = in_frame_reg;
            end
        end
        else if (verdict.is_event && (ext_reg < EXT_W'(MAX_EXTEND)))
        begin
            if (held_reg.duration != DUR_MAX)
                held_next.duration = held_reg.duration + DUR_W'(1);
            ext_next = ext_reg + EXT_W'(1);
        end
        else
        begin
            emit_next  = 1'b1;
            kind_next  = hkind_reg;
            out_next   = held_reg;
            ext_next   = '0;
            accum_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            accum_reg     <= 1'b0;
            good_reg      <= '0;
            ext_reg       <= '0;
        end
        else
        begin
            if (frame.valid && frame.ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                accum_reg <= accum_next;
                good_reg  <= good_next;
                ext_reg   <= ext_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            in_frame_reg.tag      <= frame.frame_tag;
            in_frame_reg.freq     <= frame.freq_meas;
            in_frame_reg.vrms     <= frame.vrms_meas;
            in_frame_reg.duration <= frame.frame_duration;
        end
        if (advance)
        begin
            held_reg  <= held_next;
            hkind_reg <= hkind_next;
            emit_reg  <= emit_next;
            kind_reg  <= kind_next;
            out_reg   <= out_next;
            led_reg   <= led_next;
        end
    end

    // result beat
    assign result.valid        = out_valid_reg;
    assign result.emit         = emit_reg;
    assign result.event_kind   = kind_reg;
    assign result.out_tag      = out_reg.tag;
    assign result.out_freq     = out_reg.freq;
    assign result.out_vrms     = out_reg.vrms;
    assign result.out_duration = out_reg.duration;
    assign result.led_on       = led_reg;

endmodule

`default_nettype wire

// ===== test/grid_deviation_event_filter_tb.sv =====
// self-checking testbench of the grid deviation event filter: directed table, then random frames
`timescale 1ns / 100ps

module grid_deviation_event_filter_tb;
    import gdef_pkg::*;

    localparam int MERGE_LIMIT   = MAX_EXTEND_DEF;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_FRAMES  = 215;
    localparam int GOOD_RUN      = 40;

    // one result beat as the filter should produce it
    typedef struct packed {
        logic              emit;
        kind_t             kind;
        logic [TAG_W-1:0]  tag;
        logic [FREQ_W-1:0] freq;
        logic [VRMS_W-1:0] vrms;
        logic [DUR_W-1:0]  duration;
        logic              led;
    } verdict_t;

    // one row of the directed table: a register write or a run of equal frames
    typedef struct {
        bit                is_write;
        reg_addr_t         addr;
        logic [DATA_W-1:0] data;
        int                reps;
        frame_t            frm;
        bit                typed;
        verdict_t          want;
    } step_t;

    logic clk;
    logic rst_n;

    gdef_frame_if  frame_ch ();
    gdef_result_if result_ch ();
    gdef_cfg_if    cfg_ch ();

    grid_deviation_event_filter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // filter settings as the testbench tracks them
    logic [FREQ_W-1:0] nom_freq;
    logic [VRMS_W-1:0] nom_vrms;
    logic [FREQ_W-1:0] freq_thr;
    logic [VRMS_W-1:0] vrms_thr;
    logic [15:0]       meas_period;

    // filter state as the testbench tracks it
    bit                merging;
    logic [GOOD_W-1:0] good_run_cnt;
    int                merges;
    frame_t            held;
    kind_t             held_kind;

    verdict_t pending_results[$];
    int       error_count;
    int       quiet_cycles;
    int       stall_left;
    bit       calm;
    int       burst_left;
    bit       burst_event;

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [FREQ_W-1:0] span(input logic [FREQ_W-1:0] a,
                                               input logic [FREQ_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // classify one frame and advance the merge state, giving the result beat it causes
    function automatic verdict_t filter_frame(input frame_t f);
        verdict_t v;
        bit       hit;
        bit       meas;
        kind_t    kind;
        v    = '0;
        hit  = 1'b0;
        meas = 1'b0;
        kind = KIND_FREQ;
        // priority: frequency, then voltage, then good
        if (span(nom_freq, f.freq) >= freq_thr)
        begin
            hit = 1'b1;
        end
        else if (span(FREQ_W'(nom_vrms), FREQ_W'(f.vrms)) >= FREQ_W'(vrms_thr))
        begin
            hit  = 1'b1;
            kind = KIND_VOLT;
        end
        else
        begin
            if (good_run_cnt != GOOD_MAX)
                good_run_cnt++;
            if (meas_period != 0 && good_run_cnt > GOOD_W'(meas_period))
            begin
                good_run_cnt = '0;
                meas         = 1'b1;
                kind         = KIND_MEAS;
            end
        end
        if (hit)
            good_run_cnt = '0;

        // idle: hold an event, pass a measurement through
        if (!merging)
        begin
            if (hit)
            begin
                held      = f;
                held_kind = kind;
                merging   = 1'b1;
            end
            else if (meas)
            begin
                v.emit     = 1'b1;
                v.kind     = KIND_MEAS;
                v.tag      = f.tag;
                v.freq     = f.freq;
                v.vrms     = f.vrms;
                v.duration = f.duration;
            end
        end
        // merging: extend the held duration, saturating
        else if (hit && merges < MERGE_LIMIT)
        begin
            if (held.duration != DUR_MAX)
                held.duration++;
            merges++;
        end
        // release the held frame, drop this one
        else
        begin
            v.emit     = 1'b1;
            v.kind     = held_kind;
            v.tag      = held.tag;
            v.freq     = held.freq;
            v.vrms     = held.vrms;
            v.duration = held.duration;
            merges     = 0;
            merging    = 1'b0;
        end
        v.led = hit || meas;
        return v;
    endfunction

    function automatic verdict_t beat(input bit emit, input kind_t kind,
                                      input logic [TAG_W-1:0] tag, input logic [FREQ_W-1:0] freq,
                                      input logic [VRMS_W-1:0] vrms,
                                      input logic [DUR_W-1:0] duration, input bit led);
        verdict_t v;
        v.emit     = emit;
        v.kind     = kind;
        v.tag      = tag;
        v.freq     = freq;
        v.vrms     = vrms;
        v.duration = duration;
        v.led      = led;
        return v;
    endfunction

    function automatic step_t frame_step(input int reps, input logic [TAG_W-1:0] tag,
                                         input logic [FREQ_W-1:0] freq,
                                         input logic [VRMS_W-1:0] vrms,
                                         input logic [DUR_W-1:0] duration,
                                         input bit typed, input verdict_t want);
        step_t s;
        s.is_write       = 1'b0;
        s.addr           = REG_FREQ_EXP;
        s.data           = '0;
        s.reps           = reps;
        s.frm.tag        = tag;
        s.frm.freq       = freq;
        s.frm.vrms       = vrms;
        s.frm.duration   = duration;
        s.typed          = typed;
        s.want           = want;
        return s;
    endfunction

    function automatic step_t write_step(input reg_addr_t a, input logic [DATA_W-1:0] d);
        step_t s;
        s          = frame_step(0, '0, '0, '0, '0, 1'b0, '0);
        s.is_write = 1'b1;
        s.addr     = a;
        s.data     = d;
        return s;
    endfunction

    // a value at a chosen distance from nominal: past the threshold or inside it
    function automatic int near_value(input int nominal, input int thr, input bit hit,
                                      input int top);
        int offset;
        int v;
        if (hit)
            offset = thr + int'($urandom_range(0, 40));
        else
            offset = (thr == 0) ? 0 : int'($urandom_range(0, thr - 1));
        v = $urandom_range(0, 1) ? nominal + offset : nominal - offset;
        if (v < 0)
            v = nominal + offset;
        if (v > top)
            v = top;
        return v;
    endfunction

    // random frames in bursts of events and of good frames, with some noise
    function automatic frame_t random_frame();
        frame_t f;
        bit     freq_hit;
        bit     vrms_hit;
        if (burst_left == 0)
        begin
            burst_event = $urandom_range(0, 1);
            if (burst_event)
                burst_left = $urandom_range(1, 20);
            else
                burst_left = $urandom_range(1, (meas_period < 17) ? int'(meas_period) + 3 : 20);
        end
        burst_left--;
        freq_hit   = burst_event && $urandom_range(0, 1);
        vrms_hit   = burst_event && (!freq_hit || $urandom_range(0, 1));
        f.tag      = TAG_W'($urandom);
        f.freq     = FREQ_W'(near_value(int'(nom_freq), int'(freq_thr), freq_hit, 262143));
        f.vrms     = VRMS_W'(near_value(int'(nom_vrms), int'(vrms_thr), vrms_hit, 65535));
        if ($urandom_range(0, 3) == 0)
            f.duration = DUR_W'(DUR_MAX - $urandom_range(0, 20));
        else
            f.duration = DUR_W'($urandom);
        if ($urandom_range(0, 9) == 0)
        begin
            f.freq = FREQ_W'($urandom);
            f.vrms = VRMS_W'($urandom);
        end
        return f;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp, input logic [TAG_W-1:0] tag);
        if (got !== exp)
            report_mismatch($sformatf("%s got %0h, expected %0h (expected tag %0h)",
                                      name, got, exp, tag));
    endtask

    // drive one frame beat, with an occasional gap in front
    task automatic send_frame(input frame_t f, input bit typed, input verdict_t want);
        verdict_t got;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        frame_ch.valid          <= 1'b1;
        frame_ch.frame_tag      <= f.tag;
        frame_ch.freq_meas      <= f.freq;
        frame_ch.vrms_meas      <= f.vrms;
        frame_ch.frame_duration <= f.duration;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        got = filter_frame(f);
        pending_results.push_back(typed ? want : got);
    endtask

    // stop sending and wait until every result beat is back
    task automatic drain();
        frame_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_addr_t a, input logic [DATA_W-1:0] d);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= a;
        cfg_ch.data  <= d;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (a)
            REG_FREQ_EXP: nom_freq    = d[FREQ_W-1:0];
            REG_VRMS_EXP: nom_vrms    = d[VRMS_W-1:0];
            REG_FREQ_THR: freq_thr    = d[FREQ_W-1:0];
            REG_VRMS_THR: vrms_thr    = d[VRMS_W-1:0];
            REG_MEAS_PER: meas_period = d[15:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [FREQ_W-1:0] fe, input logic [VRMS_W-1:0] ve,
                             input logic [FREQ_W-1:0] ft, input logic [VRMS_W-1:0] vt,
                             input logic [15:0] mp);
        write_reg(REG_FREQ_EXP, DATA_W'(fe));
        write_reg(REG_VRMS_EXP, DATA_W'(ve));
        write_reg(REG_FREQ_THR, DATA_W'(ft));
        write_reg(REG_VRMS_THR, DATA_W'(vt));
        write_reg(REG_MEAS_PER, DATA_W'(mp));
    endtask

    // result ready with random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left      <= stall_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left      <= $urandom_range(0, 17);
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    // compare each result beat with the oldest pending one
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing pending, tag %0h",
                                          result_ch.out_tag));
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("emit", result_ch.emit, want.emit, want.tag);
                check_field("event_kind", result_ch.event_kind, want.kind, want.tag);
                check_field("out_tag", result_ch.out_tag, want.tag, want.tag);
                check_field("out_freq", result_ch.out_freq, want.freq, want.tag);
                check_field("out_vrms", result_ch.out_vrms, want.vrms, want.tag);
                check_field("out_duration", result_ch.out_duration, want.duration, want.tag);
                check_field("led_on", result_ch.led_on, want.led, want.tag);
            end
        end
    end

    // watchdog: too long without any beat on any channel
    always @(posedge clk)
    begin
        if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[grid_deviation_event_filter] ERROR");
            $finish;
        end
    end

    initial
    begin
        step_t    plan[$];
        verdict_t flagged;
        frame_t   f;

        // known values on every input
        rst_n                   = 1'b0;
        frame_ch.valid          = 1'b0;
        frame_ch.frame_tag      = '0;
        frame_ch.freq_meas      = '0;
        frame_ch.vrms_meas      = '0;
        frame_ch.frame_duration = '0;
        result_ch.ready         = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.addr             = '0;
        cfg_ch.data             = '0;
        calm                    = 1'b0;
        stall_left              = 0;
        error_count             = 0;
        quiet_cycles            = 0;
        burst_left              = 0;
        burst_event             = 1'b0;

        // tracked state after reset
        nom_freq     = FREQ_EXP_RST;
        nom_vrms     = VRMS_EXP_RST;
        freq_thr     = FREQ_THR_RST;
        vrms_thr     = VRMS_THR_RST;
        meas_period  = MEAS_PER_RST;
        merging      = 1'b0;
        good_run_cnt = '0;
        merges       = 0;
        held         = '0;
        held_kind    = KIND_FREQ;

        flagged = beat(1'b0, KIND_FREQ, '0, '0, '0, '0, 1'b1);

        // directed table
        // good frame right after reset: nothing emitted, led dark
        plan.push_back(frame_step(1, 16'h0001, 60000, 12000, 5, 1'b1,
                                  beat(1'b0, KIND_FREQ, '0, '0, '0, '0, 1'b0)));
        // frequency event with every field at an extreme is held
        plan.push_back(frame_step(1, 16'hFFFF, 0, 0, 16'hFFFF, 1'b1, flagged));
        // voltage event merges; held duration already at its ceiling
        plan.push_back(frame_step(1, 16'h0002, 60000, 0, 0, 1'b1, flagged));
        // good frame just inside both thresholds releases the held frame
        plan.push_back(frame_step(1, 16'h0003, 60099, 12499, 7, 1'b1,
                                  beat(1'b1, KIND_FREQ, 16'hFFFF, 0, 0, 16'hFFFF, 1'b0)));
        // deviation exactly at the frequency threshold
        plan.push_back(frame_step(1, 16'h0004, 60100, 12000, 10, 1'b1, flagged));
        // merges up to the extension limit
        plan.push_back(frame_step(MERGE_LIMIT, 16'h0100, 18'h3FFFF, 16'hFFFF, 0, 1'b1,
                                  flagged));
        // one event past the limit releases the held frame and is dropped
        plan.push_back(frame_step(1, 16'h0007, 18'h3FFFF, 0, 0, 1'b1,
                                  beat(1'b1, KIND_FREQ, 16'h0004, 60100, 12000, 25, 1'b1)));
        // deviation exactly at the voltage threshold, then release by a good frame
        plan.push_back(frame_step(1, 16'h0030, 60000, 12500, 1, 1'b1, flagged));
        plan.push_back(frame_step(1, 16'h0031, 60000, 12000, 2, 1'b1,
                                  beat(1'b1, KIND_VOLT, 16'h0030, 60000, 12500, 1, 1'b0)));
        // zero threshold: any frame is a frequency event
        plan.push_back(write_step(REG_FREQ_EXP, 0));
        plan.push_back(write_step(REG_FREQ_THR, 0));
        plan.push_back(frame_step(1, 16'h0055, 0, 0, 0, 1'b1, flagged));
        // widest nominal and threshold: only the far end deviates
        plan.push_back(write_step(REG_FREQ_EXP, 18'h3FFFF));
        plan.push_back(write_step(REG_FREQ_THR, 18'h3FFFF));
        plan.push_back(frame_step(1, 16'h0056, 0, 0, 0, 1'b1, flagged));
        plan.push_back(frame_step(1, 16'h0057, 1, 12000, 0, 1'b1,
                                  beat(1'b1, KIND_FREQ, 16'h0055, 0, 0, 1, 1'b0)));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_write)
                write_reg(plan[i].addr, plan[i].data);
            else
                repeat (plan[i].reps)
                    send_frame(plan[i].frm, plan[i].typed, plan[i].want);
        end

        // good run with measurements off, then a period below the count
        // turns the next good frame into a measurement at once
        write_all(FREQ_EXP_RST, VRMS_EXP_RST, FREQ_THR_RST, VRMS_THR_RST, 16'd0);
        calm = 1'b1;
        repeat (GOOD_RUN)
        begin
            f.tag      = TAG_W'($urandom);
            f.freq     = FREQ_EXP_RST;
            f.vrms     = VRMS_EXP_RST;
            f.duration = DUR_W'($urandom);
            send_frame(f, 1'b0, '0);
        end
        write_reg(REG_MEAS_PER, DATA_W'(GOOD_RUN));
        f.tag      = 16'hABCD;
        f.freq     = 60050;
        f.vrms     = 12100;
        f.duration = 16'h1234;
        send_frame(f, 1'b1, beat(1'b1, KIND_MEAS, 16'hABCD, 60050, 12100, 16'h1234, 1'b1));

        // random phases, each under its own settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: write_all(FREQ_EXP_RST, VRMS_EXP_RST, FREQ_THR_RST, VRMS_THR_RST,
                             16'($urandom_range(1, 6)));
                1: write_all(FREQ_W'($urandom), VRMS_W'($urandom),
                             FREQ_W'($urandom_range(0, 3000)), VRMS_W'($urandom_range(0, 3000)),
                             16'd0);
                2: write_all(18'h3FFFF, 16'hFFFF, 18'h3FFFF, 16'hFFFF, 16'd1);
                3: write_all('0, '0, '0, '0, 16'hFFFF);
                4: write_all(50000, 23000, 1, 1, 16'd3);
                5: write_all(FREQ_W'($urandom), VRMS_W'($urandom), FREQ_W'($urandom),
                             VRMS_W'($urandom), 16'($urandom_range(0, 10)));
                default: write_all(FREQ_EXP_RST, VRMS_EXP_RST, FREQ_THR_RST, VRMS_THR_RST,
                                   16'd2);
            endcase
            // no idling in the zero-threshold phase and in the last one
            calm       = (p == 3) || (p == RANDOM_PHASES - 1);
            burst_left = 0;
            repeat (PHASE_FRAMES)
                send_frame(random_frame(), 1'b0, '0);
        end

        drain();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("[grid_deviation_event_filter] OK");
        else
            $display("[grid_deviation_event_filter] ERROR");
        $finish;
    end

endmodule
